// ===== rtl/core/c2p_pkg.sv =====
// Shared types, constants and lookup tables of the cartesian-to-polar converter.
package c2p_pkg;

  localparam int unsigned QuoW = 17;
  localparam int unsigned DivStages = QuoW;
  localparam int unsigned CoreLat = DivStages + 4;
  localparam int unsigned TotalLat = 2 * CoreLat + 2;

  localparam logic [15:0] AtanEighth = 16'h2000;
  localparam logic [15:0] AtanQuarter = 16'h4000;
  localparam logic [15:0] AtanHalf = 16'h8000;
  localparam logic [15:0] SqrtEqual = 16'd27146;
  localparam logic [31:0] RoundHalf = 32'h0000_8000;
  localparam logic [7:0] IdxLast = 8'hff;

  typedef struct packed {
    logic        three;
    logic        nx;
    logic        ny;
    logic        nz;
    logic [29:0] az;
    logic [15:0] heading;
    logic [31:0] plen;
    logic [15:0] plane;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] big;
    logic        eq;
    logic        swapped;
  } core_pay_t;

  localparam logic [15:0] AtanRom [256] = '{
    16'd0, 16'd41, 16'd81, 16'd122, 16'd163, 16'd204, 16'd244, 16'd285, 16'd326, 16'd367,
    16'd407, 16'd448, 16'd489, 16'd529, 16'd570, 16'd610, 16'd651,
    16'd692, 16'd732, 16'd773, 16'd813, 16'd854, 16'd894, 16'd935, 16'd975, 16'd1015,
    16'd1056, 16'd1096, 16'd1136, 16'd1177, 16'd1217, 16'd1257, 16'd1297, 16'd1337,
    16'd1377, 16'd1417, 16'd1457, 16'd1497, 16'd1537, 16'd1577, 16'd1617, 16'd1656,
    16'd1696, 16'd1736, 16'd1775, 16'd1815, 16'd1854, 16'd1894, 16'd1933, 16'd1973, 16'd2012,
    16'd2051, 16'd2090, 16'd2129, 16'd2168, 16'd2207, 16'd2246, 16'd2285, 16'd2324,
    16'd2363, 16'd2401, 16'd2440, 16'd2478, 16'd2517, 16'd2555, 16'd2593, 16'd2632, 16'd2670,
    16'd2708, 16'd2746, 16'd2784, 16'd2822, 16'd2860, 16'd2897, 16'd2935, 16'd2973,
    16'd3010, 16'd3047, 16'd3085, 16'd3122, 16'd3159, 16'd3196, 16'd3233, 16'd3270, 16'd3307,
    16'd3344, 16'd3380, 16'd3417, 16'd3453, 16'd3490, 16'd3526, 16'd3562, 16'd3598,
    16'd3634, 16'd3670, 16'd3706, 16'd3742, 16'd3778, 16'd3813, 16'd3849, 16'd3884, 16'd3920,
    16'd3955, 16'd3990, 16'd4025, 16'd4060, 16'd4095, 16'd4129, 16'd4164, 16'd4199,
    16'd4233, 16'd4267, 16'd4302, 16'd4336, 16'd4370, 16'd4404, 16'd4438, 16'd4471, 16'd4505,
    16'd4539, 16'd4572, 16'd4605, 16'd4639, 16'd4672, 16'd4705, 16'd4738, 16'd4771,
    16'd4803, 16'd4836, 16'd4869, 16'd4901, 16'd4933, 16'd4966, 16'd4998, 16'd5030, 16'd5062,
    16'd5093, 16'd5125, 16'd5157, 16'd5188, 16'd5220, 16'd5251, 16'd5282, 16'd5313,
    16'd5344, 16'd5375, 16'd5406, 16'd5437, 16'd5467, 16'd5498, 16'd5528, 16'd5558, 16'd5589,
    16'd5619, 16'd5649, 16'd5679, 16'd5708, 16'd5738, 16'd5768, 16'd5797, 16'd5826,
    16'd5856, 16'd5885, 16'd5914, 16'd5943, 16'd5972, 16'd6000, 16'd6029, 16'd6057, 16'd6086,
    16'd6114, 16'd6142, 16'd6171, 16'd6199, 16'd6226, 16'd6254, 16'd6282, 16'd6310,
    16'd6337, 16'd6365, 16'd6392, 16'd6419, 16'd6446, 16'd6473, 16'd6500, 16'd6527, 16'd6554,
    16'd6580, 16'd6607, 16'd6633, 16'd6660, 16'd6686, 16'd6712, 16'd6738, 16'd6764,
    16'd6790, 16'd6815, 16'd6841, 16'd6867, 16'd6892, 16'd6917, 16'd6943, 16'd6968, 16'd6993,
    16'd7018, 16'd7043, 16'd7067, 16'd7092, 16'd7117, 16'd7141, 16'd7166, 16'd7190,
    16'd7214, 16'd7238, 16'd7262, 16'd7286, 16'd7310, 16'd7334, 16'd7358, 16'd7381, 16'd7405,
    16'd7428, 16'd7451, 16'd7474, 16'd7498, 16'd7521, 16'd7544, 16'd7566, 16'd7589,
    16'd7612, 16'd7634, 16'd7657, 16'd7679, 16'd7702, 16'd7724, 16'd7746, 16'd7768, 16'd7790,
    16'd7812, 16'd7834, 16'd7856, 16'd7877, 16'd7899, 16'd7920, 16'd7942, 16'd7963,
    16'd7984, 16'd8005, 16'd8026, 16'd8047, 16'd8068, 16'd8089, 16'd8110, 16'd8130, 16'd8151,
    16'd8172
  };

  localparam logic [15:0] SqrtRom [256] = '{
    16'd0, 16'd0, 16'd2, 16'd4, 16'd8, 16'd12, 16'd18, 16'd24, 16'd32, 16'd40, 16'd50,
    16'd60, 16'd72, 16'd84, 16'd98,
    16'd112, 16'd128, 16'd144, 16'd162, 16'd180, 16'd200, 16'd220, 16'd242, 16'd264,
    16'd287, 16'd312, 16'd337, 16'd363, 16'd391, 16'd419,
    16'd448, 16'd479, 16'd510, 16'd542, 16'd575, 16'd610, 16'd645, 16'd681, 16'd718,
    16'd756, 16'd795, 16'd835, 16'd876, 16'd918, 16'd961,
    16'd1005, 16'd1050, 16'd1095, 16'd1142, 16'd1190, 16'd1238, 16'd1288, 16'd1338,
    16'd1390, 16'd1442, 16'd1495, 16'd1550, 16'd1605, 16'd1661, 16'd1718,
    16'd1776, 16'd1835, 16'd1895, 16'd1955, 16'd2017, 16'd2079, 16'd2143, 16'd2207,
    16'd2273, 16'd2339, 16'd2406, 16'd2474, 16'd2543, 16'd2612, 16'd2683,
    16'd2755, 16'd2827, 16'd2900, 16'd2974, 16'd3049, 16'd3125, 16'd3202, 16'd3280,
    16'd3358, 16'd3438, 16'd3518, 16'd3599, 16'd3681, 16'd3764, 16'd3847,
    16'd3932, 16'd4017, 16'd4103, 16'd4190, 16'd4278, 16'd4367, 16'd4456, 16'd4547,
    16'd4638, 16'd4730, 16'd4822, 16'd4916, 16'd5010, 16'd5105, 16'd5201,
    16'd5298, 16'd5396, 16'd5494, 16'd5593, 16'd5693, 16'd5794, 16'd5895, 16'd5997,
    16'd6100, 16'd6204, 16'd6309, 16'd6414, 16'd6520, 16'd6627, 16'd6734,
    16'd6843, 16'd6952, 16'd7061, 16'd7172, 16'd7283, 16'd7395, 16'd7508, 16'd7621,
    16'd7735, 16'd7850, 16'd7966, 16'd8082, 16'd8199, 16'd8317, 16'd8435,
    16'd8554, 16'd8674, 16'd8794, 16'd8915, 16'd9037, 16'd9160, 16'd9283, 16'd9407,
    16'd9531, 16'd9656, 16'd9782, 16'd9909, 16'd10036, 16'd10164, 16'd10292,
    16'd10421, 16'd10551, 16'd10681, 16'd10812, 16'd10944, 16'd11076, 16'd11209, 16'd11343,
    16'd11477, 16'd11612, 16'd11747, 16'd11883, 16'd12019, 16'd12157, 16'd12294,
    16'd12433, 16'd12572, 16'd12711, 16'd12852, 16'd12992, 16'd13134, 16'd13276, 16'd13418,
    16'd13561, 16'd13705, 16'd13849, 16'd13994, 16'd14139, 16'd14285, 16'd14431,
    16'd14578, 16'd14726, 16'd14874, 16'd15022, 16'd15171, 16'd15321, 16'd15471, 16'd15622,
    16'd15773, 16'd15925, 16'd16077, 16'd16230, 16'd16384, 16'd16537, 16'd16692,
    16'd16847, 16'd17002, 16'd17158, 16'd17314, 16'd17471, 16'd17629, 16'd17786, 16'd17945,
    16'd18104, 16'd18263, 16'd18423, 16'd18583, 16'd18744, 16'd18905, 16'd19066,
    16'd19229, 16'd19391, 16'd19554, 16'd19718, 16'd19882, 16'd20046, 16'd20211, 16'd20376,
    16'd20542, 16'd20708, 16'd20875, 16'd21042, 16'd21209, 16'd21377, 16'd21546,
    16'd21714, 16'd21884, 16'd22053, 16'd22223, 16'd22394, 16'd22565, 16'd22736, 16'd22908,
    16'd23080, 16'd23252, 16'd23425, 16'd23599, 16'd23772, 16'd23946, 16'd24121,
    16'd24296, 16'd24471, 16'd24647, 16'd24823, 16'd24999, 16'd25176, 16'd25353, 16'd25531,
    16'd25709, 16'd25887, 16'd26066, 16'd26245, 16'd26424, 16'd26604, 16'd26784,
    16'd26964
  };

endpackage

// ===== rtl/core/c2p_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a carried payload.
module c2p_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [31:0]         dividend_i,
  input  logic [15:0]         divisor_i,
  input  c2p_pkg::core_pay_t  pay_i,
  output logic                valid_o,
  output logic [c2p_pkg::QuoW-1:0] quo_o,
  output c2p_pkg::core_pay_t  pay_o
);
  import c2p_pkg::*;

  logic              valid_q [DivStages];
  logic [31:0]       rem_q   [DivStages];
  logic [QuoW-1:0]   quo_q   [DivStages];
  logic [15:0]       dvs_q   [DivStages];
  core_pay_t         pay_q   [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    localparam int unsigned Bit = QuoW - 1 - k;
    logic              valid_in;
    logic [31:0]       rem_in;
    logic [QuoW-1:0]   quo_in;
    logic [15:0]       dvs_in;
    core_pay_t         pay_in;
    logic [32:0]       trial;
    logic [31:0]       rem_d;
    logic [QuoW-1:0]   quo_d;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = dividend_i;
      assign quo_in   = '0;
      assign dvs_in   = divisor_i;
      assign pay_in   = pay_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign dvs_in   = dvs_q[k-1];
      assign pay_in   = pay_q[k-1];
    end

    always_comb begin
      trial = {1'b0, rem_in} - (33'(dvs_in) << Bit);
      rem_d = rem_in;
      quo_d = quo_in;
      if (!trial[32]) begin
        rem_d      = trial[31:0];
        quo_d[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      quo_q[k] <= quo_d;
      dvs_q[k] <= dvs_in;
      pay_q[k] <= pay_in;
    end
  end

  assign valid_o = valid_q[DivStages-1];
  assign quo_o   = quo_q[DivStages-1];
  assign pay_o   = pay_q[DivStages-1];

endmodule

// ===== rtl/core/c2p_core.sv =====
// One polar core pass: order, normalize, divide, interpolate tables, form ratio and length.
module c2p_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [31:0]    p_i,
  input  logic [31:0]    q_i,
  input  c2p_pkg::side_t side_i,
  output logic           valid_o,
  output logic [15:0]    ratio_o,
  output logic [31:0]    len_o,
  output c2p_pkg::side_t side_o
);
  import c2p_pkg::*;

  logic        eq, swapped;
  logic [31:0] big, lesser, lo1, hi1, lo2, hi2;
  logic        n_valid_q;
  logic [31:0] n_hi_q;
  logic [15:0] n_dvs_q;
  core_pay_t   n_pay_q;

  always_comb begin
    eq      = (p_i == q_i);
    swapped = (p_i < q_i);
    big     = swapped ? q_i : p_i;
    lesser  = swapped ? p_i : q_i;
    lo1     = big;
    hi1     = lesser;
    if (big[31:24] == 8'd0) begin
      lo1 = big << 8;
      hi1 = lesser << 8;
    end
    lo2 = lo1;
    hi2 = hi1;
    if (big[31:24] == 8'd0 && lo1[31:24] == 8'd0) begin
      lo2 = lo1 << 8;
      hi2 = hi1 << 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else begin
      n_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_hi_q          <= hi2;
    n_dvs_q         <= lo2[31:16];
    n_pay_q.side    <= side_i;
    n_pay_q.big     <= big;
    n_pay_q.eq      <= eq;
    n_pay_q.swapped <= swapped;
  end

  logic            d_valid;
  logic [QuoW-1:0] d_quo;
  core_pay_t       d_pay;

  c2p_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (n_valid_q),
    .dividend_i (n_hi_q),
    .divisor_i  (n_dvs_q),
    .pay_i      (n_pay_q),
    .valid_o    (d_valid),
    .quo_o      (d_quo),
    .pay_o      (d_pay)
  );

  logic [7:0]  idx, f8;
  logic [15:0] base_d, next_d, root_d, diff_d;
  logic [7:0]  frac_d;
  logic        r_valid_q;
  logic [15:0] r_base_q, r_diff_q, r_root_q;
  logic [7:0]  r_frac_q;
  core_pay_t   r_pay_q;

  always_comb begin
    idx    = d_quo[15:8];
    f8     = d_quo[7:0];
    base_d = AtanRom[idx];
    next_d = (idx == IdxLast) ? AtanEighth : AtanRom[idx + 8'd1];
    root_d = SqrtRom[idx];
    frac_d = f8;
    if (d_pay.eq) begin
      base_d = AtanEighth;
      next_d = AtanEighth;
      root_d = SqrtEqual;
      frac_d = 8'd0;
    end
    diff_d = next_d - base_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else begin
      r_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    r_base_q <= base_d;
    r_diff_q <= diff_d;
    r_root_q <= root_d;
    r_frac_q <= frac_d;
    r_pay_q  <= d_pay;
  end

  logic        m_valid_q;
  logic [15:0] m_base_q;
  logic [23:0] m_interp_q;
  logic [31:0] m_hi_q, m_lo_q;
  core_pay_t   m_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_base_q   <= r_base_q;
    m_interp_q <= r_diff_q * r_frac_q;
    m_hi_q     <= r_root_q * r_pay_q.big[31:16];
    m_lo_q     <= r_root_q * r_pay_q.big[15:0];
    m_pay_q    <= r_pay_q;
  end

  logic [15:0] ratio_d;
  logic [31:0] round_sum, len_d;
  logic        f_valid_q;
  logic [15:0] f_ratio_q;
  logic [31:0] f_len_q;
  side_t       f_side_q;

  always_comb begin
    ratio_d = m_base_q + m_interp_q[23:8];
    if (m_pay_q.swapped) begin
      ratio_d = AtanQuarter - ratio_d;
    end
    round_sum = m_lo_q + RoundHalf;
    len_d     = m_hi_q + m_pay_q.big + {16'd0, round_sum[31:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_ratio_q <= ratio_d;
    f_len_q   <= len_d;
    f_side_q  <= m_pay_q.side;
  end

  assign valid_o = f_valid_q;
  assign ratio_o = f_ratio_q;
  assign len_o   = f_len_q;
  assign side_o  = f_side_q;

endmodule

// ===== rtl/core/cartesian_to_polar_fixed.sv =====
// Top level of the pipelined table-based cartesian-to-polar converter.
//
//   channel   direction  handshake          payload
//   command   in         start_i / busy_o   off_x_i, off_y_i, off_z_i, three_dim_i
//   result    out        done_o strobe      heading_o, pitch_o, distance_o, plane_angle_o
//
// One word enters per cycle; its result leaves after the input stage, two core passes
// of 21 stages each, and the output stage. Each core pass holds a 17-stage divider,
// one quotient bit per stage. busy_o stays low: the pipeline never stalls.
// Reset clears only the valid bits; no result appears until a word is taken.
module cartesian_to_polar_fixed (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [29:0] off_x_i,
  input  logic [29:0] off_y_i,
  input  logic [29:0] off_z_i,
  input  logic        three_dim_i,
  output logic        done_o,
  output logic [15:0] heading_o,
  output logic [15:0] pitch_o,
  output logic [31:0] distance_o,
  output logic [15:0] plane_angle_o
);
  import c2p_pkg::*;

  function automatic logic [29:0] mag30(input logic [29:0] v);
    return v[29] ? (~v + 30'd1) : v;
  endfunction

  logic        a_valid_q;
  logic [29:0] a_ax_q, a_ay_q;
  side_t       a_side_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ax_q           <= mag30(off_x_i);
    a_ay_q           <= mag30(off_y_i);
    a_side_q.three   <= three_dim_i;
    a_side_q.nx      <= off_x_i[29];
    a_side_q.ny      <= off_y_i[29];
    a_side_q.nz      <= off_z_i[29];
    a_side_q.az      <= mag30(off_z_i);
    a_side_q.heading <= '0;
    a_side_q.plen    <= '0;
    a_side_q.plane   <= '0;
  end

  logic        c1_valid;
  logic [15:0] c1_ratio;
  logic [31:0] c1_len;
  side_t       c1_side;

  c2p_core u_core_plane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid_q),
    .p_i     ({2'b00, a_ax_q}),
    .q_i     ({2'b00, a_ay_q}),
    .side_i  (a_side_q),
    .valid_o (c1_valid),
    .ratio_o (c1_ratio),
    .len_o   (c1_len),
    .side_o  (c1_side)
  );

  logic [15:0] h_fold;
  side_t       side2;

  always_comb begin
    h_fold = c1_ratio;
    if (c1_side.ny) begin
      h_fold = 16'd0 - h_fold;
    end
    if (c1_side.nx) begin
      h_fold = AtanHalf - h_fold;
    end
    side2         = c1_side;
    side2.heading = AtanQuarter - h_fold;
    side2.plen    = c1_len;
    side2.plane   = c1_ratio;
  end

  logic        c2_valid;
  logic [15:0] c2_ratio;
  logic [31:0] c2_len;
  side_t       c2_side;

  c2p_core u_core_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1_valid),
    .p_i     (c1_len),
    .q_i     ({2'b00, c1_side.az}),
    .side_i  (side2),
    .valid_o (c2_valid),
    .ratio_o (c2_ratio),
    .len_o   (c2_len),
    .side_o  (c2_side)
  );

  logic [15:0] p_fold;
  logic        o_valid_q;
  logic [15:0] o_heading_q, o_pitch_q, o_plane_q;
  logic [31:0] o_dist_q;

  always_comb begin
    p_fold = c2_side.nz ? (16'd0 - c2_ratio) : c2_ratio;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= c2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    o_heading_q <= c2_side.heading;
    if (c2_side.three) begin
      o_pitch_q <= AtanQuarter - p_fold;
      o_dist_q  <= c2_len;
      o_plane_q <= c2_ratio;
    end else begin
      o_pitch_q <= '0;
      o_dist_q  <= c2_side.plen;
      o_plane_q <= c2_side.plane;
    end
  end

  assign done_o        = o_valid_q;
  assign heading_o     = o_heading_q;
  assign pitch_o       = o_pitch_q;
  assign distance_o    = o_dist_q;
  assign plane_angle_o = o_plane_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(TotalLat) done_o)
    else $error("word did not leave after the pipeline latency");

  a_planar_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !three_dim_i) |-> ##(TotalLat) (pitch_o == 16'd0))
    else $error("planar word gave nonzero pitch");

  a_zero_vector : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !three_dim_i && off_x_i == 30'd0 && off_y_i == 30'd0)
      |-> ##(TotalLat) (heading_o == AtanEighth && distance_o == 32'd0))
    else $error("zero vector gave wrong heading or distance");

endmodule
